// ===== design/tcw_pkg.sv =====
package tcw_pkg;

  // Default screen size, handed to the top level as parameter defaults.
  localparam int DEFAULT_MAX_COLS = 80;
  localparam int DEFAULT_MAX_ROWS = 25;

  // Linear cell indexes never exceed 31 * 127 + 127, so 13 bits always hold them.
  localparam int LIN_MIN_W = 13;

  localparam int CFG_DATA_W = 8;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  localparam logic [7:0] CH_BACKSPACE  = 8'h08;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

  // A tab is five spaces: one at dispatch and this many more.
  localparam logic [2:0] TAB_EXTRA_SPACES = 3'd4;

  localparam logic [15:0] RAW_SPACE_CELL    = 16'h0020;
  localparam logic [15:0] RESET_BLANK_CELL  = 16'h0F20;
  localparam logic [15:0] RESET_CURSOR_CELL = 16'h0F5F;

  localparam logic [6:0] RESET_COLUMNS    = 7'd80;
  localparam logic [4:0] RESET_ROWS       = 5'd25;
  localparam logic [3:0] RESET_TEXT_COLOR = 4'd15;
  localparam logic [3:0] RESET_BACK_COLOR = 4'd0;

  typedef enum logic [1:0] {
    MODE_PUT   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_READ  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    CFG_COLUMNS          = 2'd0,
    CFG_ROWS             = 2'd1,
    CFG_TEXT_COLOR       = 2'd2,
    CFG_BACKGROUND_COLOR = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  char_code;
    logic [10:0] cell_address;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
  } out_item_t;

  typedef struct packed {
    logic [6:0] columns;
    logic [4:0] rows;
    logic [3:0] text_color;
    logic [3:0] background_color;
  } cfg_regs_t;

  typedef enum logic [2:0] {
    CMD_PUT,
    CMD_TAB,
    CMD_NEWLINE,
    CMD_BACKSPACE,
    CMD_CLEAR,
    CMD_READ,
    CMD_NOP
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [7:0]  ch;
    logic [10:0] addr;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_PUT,
    ST_BS_ERASE,
    ST_FIX,
    ST_SCROLL,
    ST_FILL,
    ST_CLEAR,
    ST_READ
  } back_state_t;

endpackage

// ===== design/tcw_front.sv =====
module tcw_front (
  input  logic              start,
  input  tcw_pkg::in_item_t item,
  input  logic              q_full,
  input  logic              init_busy,
  output logic              busy,
  output logic              push,
  output tcw_pkg::cmd_t     cmd
);

  assign busy = q_full || init_busy;
  assign push = start && !busy;

  always_comb begin
    cmd.ch   = item.char_code;
    cmd.addr = item.cell_address;
    case (item.mode)
      tcw_pkg::MODE_PUT: begin
        case (item.char_code)
          tcw_pkg::CH_NEWLINE:   cmd.op = tcw_pkg::CMD_NEWLINE;
          tcw_pkg::CH_BACKSPACE: cmd.op = tcw_pkg::CMD_BACKSPACE;
          tcw_pkg::CH_TAB:       cmd.op = tcw_pkg::CMD_TAB;
          default:               cmd.op = tcw_pkg::CMD_PUT;
        endcase
      end
      tcw_pkg::MODE_CLEAR: cmd.op = tcw_pkg::CMD_CLEAR;
      tcw_pkg::MODE_READ:  cmd.op = tcw_pkg::CMD_READ;
      default:             cmd.op = tcw_pkg::CMD_NOP;
    endcase
  end

endmodule

// ===== design/tcw_queue.sv =====
module tcw_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tcw_pkg::cmd_t din,
  input  logic          pop,
  output tcw_pkg::cmd_t dout,
  output logic          empty,
  output logic          full
);

  tcw_pkg::cmd_t                 slots [tcw_pkg::Q_DEPTH];
  logic [tcw_pkg::Q_PTR_W-1:0]   wr_ptr;
  logic [tcw_pkg::Q_PTR_W-1:0]   rd_ptr;
  logic [tcw_pkg::Q_CNT_W-1:0]   count;

  assign empty = (count == '0);
  assign full  = (count == tcw_pkg::Q_CNT_W'(tcw_pkg::Q_DEPTH));
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + tcw_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + tcw_pkg::Q_PTR_W'(1);
      end
      count <= count + tcw_pkg::Q_CNT_W'(push) - tcw_pkg::Q_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

// ===== design/tcw_back.sv =====
module tcw_back #(
  parameter int MAX_COLS = tcw_pkg::DEFAULT_MAX_COLS,
  parameter int MAX_ROWS = tcw_pkg::DEFAULT_MAX_ROWS
) (
  input  logic               clk,
  input  logic               rst,
  input  tcw_pkg::cfg_regs_t cfg,
  input  logic               q_empty,
  input  tcw_pkg::cmd_t      q_head,
  output logic               pop,
  output logic               init_busy,
  output tcw_pkg::out_item_t result,
  output logic               result_valid
);

  localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int LIN_W      = (ADDR_W + 1 > tcw_pkg::LIN_MIN_W) ? ADDR_W + 1
                                                                : tcw_pkg::LIN_MIN_W;
  localparam logic [LIN_W-1:0] CELLS = LIN_W'(CELL_COUNT);

  logic [15:0] mem [CELL_COUNT];
  logic [15:0] rdata;

  tcw_pkg::back_state_t state, state_next;
  logic [6:0]       col, col_next;
  logic [4:0]       row, row_next;
  logic [2:0]       reps, reps_next;
  logic [LIN_W-1:0] ptr, ptr_next;
  logic             pend, pend_next;
  logic [LIN_W-1:0] pend_addr, pend_addr_next;
  logic             rd_ok, rd_ok_next;

  logic [6:0]       eff_cols;
  logic [4:0]       eff_rows;
  logic [7:0]       attr;
  logic [LIN_W-1:0] cols_l;
  logic [LIN_W-1:0] area;
  logic [LIN_W-1:0] cur_idx;
  logic [LIN_W-1:0] prev_idx;
  logic [LIN_W-1:0] head_addr;
  logic             cur_ok, prev_ok, addr_ok;
  logic             col_out, row_out, scroll_more, sweep_last, init_last;

  logic             we;
  logic [LIN_W-1:0] waddr;
  logic [15:0]      wdata;
  logic [LIN_W-1:0] raddr;
  logic             res_fire;
  logic [15:0]      res_data;

  // Out-of-range register values are clamped to the usable screen size.
  always_comb begin
    if (cfg.columns == '0) begin
      eff_cols = 7'd1;
    end else if (int'(cfg.columns) > MAX_COLS) begin
      eff_cols = 7'(MAX_COLS);
    end else begin
      eff_cols = cfg.columns;
    end
    if (cfg.rows == '0) begin
      eff_rows = 5'd1;
    end else if (int'(cfg.rows) > MAX_ROWS) begin
      eff_rows = 5'(MAX_ROWS);
    end else begin
      eff_rows = cfg.rows;
    end
  end

  assign attr        = {cfg.background_color, cfg.text_color};
  assign cols_l      = LIN_W'(eff_cols);
  assign area        = LIN_W'(eff_rows) * cols_l;
  assign cur_idx     = LIN_W'(row) * cols_l + LIN_W'(col);
  assign prev_idx    = cur_idx - LIN_W'(1);
  assign head_addr   = LIN_W'(q_head.addr);
  assign cur_ok      = cur_idx < CELLS;
  assign prev_ok     = prev_idx < CELLS;
  assign addr_ok     = head_addr < CELLS;
  assign col_out     = col >= eff_cols;
  assign row_out     = row >= eff_rows;
  assign scroll_more = ptr < area;
  assign sweep_last  = ptr == area - LIN_W'(1);
  assign init_last   = ptr == CELLS - LIN_W'(1);
  assign init_busy   = (state == tcw_pkg::ST_INIT);

  always_comb begin
    state_next = state;
    case (state)
      tcw_pkg::ST_INIT: begin
        if (init_last) begin
          state_next = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (!q_empty) begin
          case (q_head.op)
            tcw_pkg::CMD_PUT,
            tcw_pkg::CMD_TAB,
            tcw_pkg::CMD_NEWLINE: state_next = tcw_pkg::ST_FIX;
            tcw_pkg::CMD_BACKSPACE: begin
              state_next = (col != '0) ? tcw_pkg::ST_BS_ERASE : tcw_pkg::ST_FIX;
            end
            tcw_pkg::CMD_CLEAR: state_next = tcw_pkg::ST_CLEAR;
            tcw_pkg::CMD_READ:  state_next = tcw_pkg::ST_READ;
            default:            state_next = tcw_pkg::ST_IDLE;
          endcase
        end
      end
      tcw_pkg::ST_PUT:      state_next = tcw_pkg::ST_FIX;
      tcw_pkg::ST_BS_ERASE: state_next = tcw_pkg::ST_FIX;
      tcw_pkg::ST_FIX: begin
        if (col_out) begin
          state_next = tcw_pkg::ST_FIX;
        end else if (row_out) begin
          state_next = tcw_pkg::ST_SCROLL;
        end else if (reps != '0) begin
          state_next = tcw_pkg::ST_PUT;
        end else begin
          state_next = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_SCROLL: begin
        if (!scroll_more && !pend) begin
          state_next = tcw_pkg::ST_FILL;
        end
      end
      tcw_pkg::ST_FILL: begin
        if (sweep_last) begin
          state_next = tcw_pkg::ST_FIX;
        end
      end
      tcw_pkg::ST_CLEAR: begin
        if (sweep_last) begin
          state_next = tcw_pkg::ST_FIX;
        end
      end
      tcw_pkg::ST_READ: state_next = tcw_pkg::ST_IDLE;
      default:          state_next = tcw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    we             = 1'b0;
    waddr          = cur_idx;
    wdata          = '0;
    raddr          = '0;
    pop            = 1'b0;
    col_next       = col;
    row_next       = row;
    reps_next      = reps;
    ptr_next       = ptr;
    pend_next      = pend;
    pend_addr_next = pend_addr;
    rd_ok_next     = rd_ok;
    res_fire       = 1'b0;
    res_data       = '0;
    case (state)
      tcw_pkg::ST_INIT: begin
        we       = 1'b1;
        waddr    = ptr;
        wdata    = (ptr == '0) ? tcw_pkg::RESET_CURSOR_CELL : tcw_pkg::RESET_BLANK_CELL;
        ptr_next = ptr + LIN_W'(1);
      end
      tcw_pkg::ST_IDLE: begin
        if (!q_empty) begin
          pop       = 1'b1;
          reps_next = '0;
          case (q_head.op)
            tcw_pkg::CMD_PUT: begin
              we       = cur_ok;
              wdata    = {attr, q_head.ch};
              col_next = col + 7'd1;
            end
            tcw_pkg::CMD_TAB: begin
              we        = cur_ok;
              wdata     = {attr, tcw_pkg::CH_SPACE};
              col_next  = col + 7'd1;
              reps_next = tcw_pkg::TAB_EXTRA_SPACES;
            end
            tcw_pkg::CMD_NEWLINE: begin
              we       = cur_ok;
              wdata    = {attr, tcw_pkg::CH_SPACE};
              col_next = '0;
              row_next = row + 5'd1;
            end
            tcw_pkg::CMD_BACKSPACE: begin
              // The cell left of the cursor is blanked without colour.
              if (col != '0) begin
                we    = prev_ok;
                waddr = prev_idx;
                wdata = tcw_pkg::RAW_SPACE_CELL;
              end
            end
            tcw_pkg::CMD_CLEAR: begin
              ptr_next = '0;
            end
            tcw_pkg::CMD_READ: begin
              raddr      = addr_ok ? head_addr : '0;
              rd_ok_next = addr_ok;
            end
            default: begin
              res_fire = 1'b1;
            end
          endcase
        end
      end
      tcw_pkg::ST_PUT: begin
        we       = cur_ok;
        wdata    = {attr, tcw_pkg::CH_SPACE};
        col_next = col + 7'd1;
      end
      tcw_pkg::ST_BS_ERASE: begin
        we       = cur_ok;
        wdata    = {attr, tcw_pkg::CH_SPACE};
        col_next = col - 7'd1;
      end
      tcw_pkg::ST_FIX: begin
        if (col_out) begin
          we       = cur_ok;
          wdata    = {attr, tcw_pkg::CH_SPACE};
          col_next = '0;
          row_next = row + 5'd1;
        end else if (row_out) begin
          ptr_next  = cols_l;
          pend_next = 1'b0;
        end else begin
          we    = cur_ok;
          wdata = {attr, tcw_pkg::CH_UNDERSCORE};
          if (reps != '0) begin
            reps_next = reps - 3'd1;
          end else begin
            res_fire = 1'b1;
          end
        end
      end
      tcw_pkg::ST_SCROLL: begin
        // Reads run one cell ahead of the writes, which land one row up.
        if (pend) begin
          we    = 1'b1;
          waddr = pend_addr;
          wdata = rdata;
        end
        if (scroll_more) begin
          raddr          = ptr;
          ptr_next       = ptr + LIN_W'(1);
          pend_next      = 1'b1;
          pend_addr_next = ptr - cols_l;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            ptr_next = area - cols_l;
          end
        end
      end
      tcw_pkg::ST_FILL: begin
        we       = 1'b1;
        waddr    = ptr;
        wdata    = tcw_pkg::RAW_SPACE_CELL;
        ptr_next = ptr + LIN_W'(1);
        if (sweep_last) begin
          col_next = '0;
          row_next = eff_rows - 5'd1;
        end
      end
      tcw_pkg::ST_CLEAR: begin
        we       = 1'b1;
        waddr    = ptr;
        wdata    = {attr, tcw_pkg::CH_SPACE};
        ptr_next = ptr + LIN_W'(1);
        if (sweep_last) begin
          col_next = '0;
          row_next = '0;
        end
      end
      tcw_pkg::ST_READ: begin
        res_fire = 1'b1;
        res_data = rd_ok ? rdata : '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= tcw_pkg::ST_INIT;
      col          <= '0;
      row          <= '0;
      reps         <= '0;
      ptr          <= '0;
      pend         <= 1'b0;
      rd_ok        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      col          <= col_next;
      row          <= row_next;
      reps         <= reps_next;
      ptr          <= ptr_next;
      pend         <= pend_next;
      rd_ok        <= rd_ok_next;
      result_valid <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr <= pend_addr_next;
    if (res_fire) begin
      result.read_data     <= res_data;
      result.cursor_column <= col;
      result.cursor_row    <= row;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr[ADDR_W-1:0]] <= wdata;
    end
    rdata <= mem[raddr[ADDR_W-1:0]];
  end

endmodule

// ===== design/text_console_writer.sv =====
// Channel   Signals                                    Direction  Handshake
// item      start, busy, item                          in         start && !busy
// result    result_valid, result                       out        one-cycle strobe
// config    cfg_valid, cfg_ready, cfg_index, cfg_data  in         cfg_valid && cfg_ready
//
// A wrap or a scroll adds work to any item that moves the cursor past the screen edge; a clear
// sweeps the whole area. Scroll and clear walk the area through the single write port of the
// memory. After reset the screen memory is swept once, all MAX_COLS*MAX_ROWS cells, with busy
// high. A two-entry queue takes items while the back end works; the receiver of results cannot
// stall.
module text_console_writer #(
  parameter int MAX_COLS = tcw_pkg::DEFAULT_MAX_COLS,
  parameter int MAX_ROWS = tcw_pkg::DEFAULT_MAX_ROWS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  tcw_pkg::in_item_t              item,
  output logic                           result_valid,
  output tcw_pkg::out_item_t             result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data
);

  tcw_pkg::cfg_regs_t cfg;
  tcw_pkg::cmd_t      push_cmd;
  tcw_pkg::cmd_t      q_head;
  logic               q_push;
  logic               q_pop;
  logic               q_empty;
  logic               q_full;
  logic               init_busy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.columns          <= tcw_pkg::RESET_COLUMNS;
      cfg.rows             <= tcw_pkg::RESET_ROWS;
      cfg.text_color       <= tcw_pkg::RESET_TEXT_COLOR;
      cfg.background_color <= tcw_pkg::RESET_BACK_COLOR;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tcw_pkg::CFG_COLUMNS:          cfg.columns          <= cfg_data[6:0];
        tcw_pkg::CFG_ROWS:             cfg.rows             <= cfg_data[4:0];
        tcw_pkg::CFG_TEXT_COLOR:       cfg.text_color       <= cfg_data[3:0];
        tcw_pkg::CFG_BACKGROUND_COLOR: cfg.background_color <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  tcw_front u_front (
    .start     (start),
    .item      (item),
    .q_full    (q_full),
    .init_busy (init_busy),
    .busy      (busy),
    .push      (q_push),
    .cmd       (push_cmd)
  );

  tcw_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (push_cmd),
    .pop   (q_pop),
    .dout  (q_head),
    .empty (q_empty),
    .full  (q_full)
  );

  tcw_back #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .pop          (q_pop),
    .init_busy    (init_busy),
    .result       (result),
    .result_valid (result_valid)
  );

  // The screen sweep after reset must keep the item port closed.
  assert property (@(posedge clk) disable iff (rst) $past(rst) |-> busy)
    else $error("busy low right after reset");

  assert property (@(posedge clk) disable iff (rst) init_busy |-> !result_valid)
    else $error("result issued during the reset sweep");

  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("item pushed into a full queue");

  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (int'(result.cursor_column) < MAX_COLS &&
                      int'(result.cursor_row) < MAX_ROWS))
    else $error("cursor reported outside the screen memory");

endmodule
